FILE: rtl/core/pgsi_pkg.sv
// ----------------------------------------------------------------------------
// Pairwise GCD stream inserter package
// Shared default value width and the sequencer state type.
// ----------------------------------------------------------------------------
package pgsi_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 31;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_ELEM
  } state_t;

endpackage

FILE: rtl/core/pairwise_gcd_stream_inserter.sv
// ----------------------------------------------------------------------------
// Pairwise GCD stream inserter
// Passes a sequence through and inserts the GCD of each neighboring pair.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_ready  value, end_of_sequence
//   out_     output     out_valid/out_ready result_value, is_divisor, last,
//                                          sequence_end
//
// The first element of a sequence is accepted and then sent as its output beat.
// A later element starts the binary GCD loop in the shared unit; the result
// is then registered into the output register and sent as two output beats,
// the divisor and then the element.
// Reset is synchronous and clears the stored element and the sequencer.
// Input is taken only while no item is in work and no beat is waiting.
// ----------------------------------------------------------------------------
module pairwise_gcd_stream_inserter #(
  parameter int unsigned VALUE_WIDTH = pgsi_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic                   in_end_of_sequence,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] out_result_value,
  output logic                   out_is_divisor,
  output logic                   out_last,
  output logic                   out_sequence_end
);

  pgsi_pkg::state_t state_r, state_nxt;

  logic                   have_r, have_nxt;
  logic [VALUE_WIDTH-1:0] prev_r, prev_nxt;
  logic [VALUE_WIDTH-1:0] elem_r, elem_nxt;
  logic                   eos_r, eos_nxt;
  logic [VALUE_WIDTH-1:0] oval_r, oval_nxt;
  logic                   odiv_r, odiv_nxt;
  logic                   olast_r, olast_nxt;
  logic                   osend_r, osend_nxt;
  logic                   gcd_start;
  logic                   gcd_done;
  logic [VALUE_WIDTH-1:0] gcd_result;
  logic                   in_acc;

  pgsi_gcd_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_gcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (gcd_start),
    .a_in   (prev_r),
    .b_in   (in_value),
    .done   (gcd_done),
    .result (gcd_result)
  );

  assign in_ready = (state_r == pgsi_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    have_nxt  = have_r;
    prev_nxt  = prev_r;
    elem_nxt  = elem_r;
    eos_nxt   = eos_r;
    oval_nxt  = oval_r;
    odiv_nxt  = odiv_r;
    olast_nxt = olast_r;
    osend_nxt = osend_r;
    gcd_start = 1'b0;
    unique case (state_r)
      pgsi_pkg::ST_IDLE: begin
        if (in_acc) begin
          elem_nxt = in_value;
          eos_nxt  = in_end_of_sequence;
          have_nxt = !in_end_of_sequence;
          prev_nxt = in_end_of_sequence ? '0 : in_value;
          if (have_r) begin
            gcd_start = 1'b1;
            state_nxt = pgsi_pkg::ST_GCD;
          end else begin
            oval_nxt  = in_value;
            odiv_nxt  = 1'b0;
            olast_nxt = 1'b1;
            osend_nxt = in_end_of_sequence;
            state_nxt = pgsi_pkg::ST_ELEM;
          end
        end
      end
      pgsi_pkg::ST_GCD: begin
        if (gcd_done) begin
          oval_nxt  = gcd_result;
          odiv_nxt  = 1'b1;
          olast_nxt = 1'b0;
          osend_nxt = 1'b0;
          state_nxt = pgsi_pkg::ST_DIV;
        end
      end
      pgsi_pkg::ST_DIV: begin
        if (out_ready) begin
          oval_nxt  = elem_r;
          odiv_nxt  = 1'b0;
          olast_nxt = 1'b1;
          osend_nxt = eos_r;
          state_nxt = pgsi_pkg::ST_ELEM;
        end
      end
      pgsi_pkg::ST_ELEM: begin
        if (out_ready) begin
          state_nxt = pgsi_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pgsi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pgsi_pkg::ST_IDLE;
      have_r  <= 1'b0;
      prev_r  <= '0;
    end else begin
      state_r <= state_nxt;
      have_r  <= have_nxt;
      prev_r  <= prev_nxt;
    end
    elem_r  <= elem_nxt;
    eos_r   <= eos_nxt;
    oval_r  <= oval_nxt;
    odiv_r  <= odiv_nxt;
    olast_r <= olast_nxt;
    osend_r <= osend_nxt;
  end

  assign out_valid        = (state_r == pgsi_pkg::ST_DIV) || (state_r == pgsi_pkg::ST_ELEM);
  assign out_result_value = oval_r;
  assign out_is_divisor   = odiv_r;
  assign out_last         = olast_r;
  assign out_sequence_end = osend_r;

endmodule

FILE: rtl/core/pgsi_gcd_unit.sv
// ----------------------------------------------------------------------------
// Iterative binary GCD unit
// One subtract, compare or halving step per cycle on a shared datapath.
// ----------------------------------------------------------------------------
module pgsi_gcd_unit #(
  parameter int unsigned VALUE_WIDTH = pgsi_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] a_in,
  input  logic [VALUE_WIDTH-1:0] b_in,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] result
);

  localparam int unsigned KW = $clog2(VALUE_WIDTH + 1);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [VALUE_WIDTH-1:0] a_r, a_nxt;
  logic [VALUE_WIDTH-1:0] b_r, b_nxt;
  logic [KW-1:0]          k_r, k_nxt;
  logic [VALUE_WIDTH-1:0] res_r, res_nxt;
  logic                   a_ge_b;
  logic [VALUE_WIDTH-1:0] diff;

  assign a_ge_b = (a_r >= b_r);
  assign diff   = a_ge_b ? (a_r - b_r) : (b_r - a_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    a_nxt    = a_r;
    b_nxt    = b_r;
    k_nxt    = k_r;
    res_nxt  = res_r;
    if (start) begin
      busy_nxt = 1'b1;
      a_nxt    = a_in;
      b_nxt    = b_in;
      k_nxt    = '0;
    end else if (busy_r) begin
      priority if (a_r == '0) begin
        res_nxt  = b_r << k_r;
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else if (b_r == '0) begin
        res_nxt  = a_r << k_r;
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else if (!a_r[0] && !b_r[0]) begin
        a_nxt = a_r >> 1;
        b_nxt = b_r >> 1;
        k_nxt = k_r + KW'(1);
      end else if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else if (a_ge_b) begin
        a_nxt = diff;
      end else begin
        b_nxt = diff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    k_r   <= k_nxt;
    res_r <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

FILE: rtl/core/pgsi_checker.sv
// ----------------------------------------------------------------------------
// Pairwise GCD stream inserter checker
// Port-level assertions on beat order and result flags.
// ----------------------------------------------------------------------------
module pgsi_checker #(
  parameter int unsigned VALUE_WIDTH = pgsi_pkg::VALUE_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic [VALUE_WIDTH-1:0] in_value,
  input logic                   in_end_of_sequence,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [VALUE_WIDTH-1:0] out_result_value,
  input logic                   out_is_divisor,
  input logic                   out_last,
  input logic                   out_sequence_end
);

  a_send_implies_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sequence_end |-> out_last)
    else $error("sequence end without last");

  a_div_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_divisor |-> !out_last && !out_sequence_end)
    else $error("divisor beat marked as last");

  a_elem_follows_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_is_divisor |=> out_valid && !out_is_divisor)
    else $error("element beat does not follow divisor beat");

  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid)
    else $error("input accepted while a result beat is pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value))
    else $error("stalled result beat changed");

endmodule

bind pairwise_gcd_stream_inserter pgsi_checker #(
  .VALUE_WIDTH(VALUE_WIDTH)
) u_pgsi_checker (.*);
